/* sv/dcs_pkg.sv */
// ----------------------------------------------------------------------------
// dcs_pkg
// shared types and constants of the distance constraint solver
// ----------------------------------------------------------------------------
package dcs_pkg;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_READ  = 2'd1,
        FN_SOLVE = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    // configuration register indexes
    localparam logic [1:0] CFG_PCOUNT = 2'd0;
    localparam logic [1:0] CFG_VTHR   = 2'd1;
    localparam logic [1:0] CFG_BTHR   = 2'd2;

    localparam int POS_W    = 32;
    localparam int STRESS_W = 24;
    localparam int PCNT_W   = 9;
    localparam int REST_W   = 31;
    localparam int STIFF_W  = 17;

    localparam logic [23:0] VTHR_RESET = 24'd3277;
    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [33:0] MIN_DIST   = 34'd65;

endpackage

/* sv/dcs_in_if.sv */
// ----------------------------------------------------------------------------
// dcs_in_if
// item channel into the solver
// ----------------------------------------------------------------------------
interface dcs_in_if;
    import dcs_pkg::*;

    logic               valid;
    logic               ready;
    t_func              func;
    logic [7:0]         first_particle;
    logic [7:0]         second_particle;
    logic [9:0]         constraint_slot;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
    logic               load_pinned;
    logic [30:0]        rest_length;
    logic [16:0]        stiffness;

    modport source (
        output valid, func, first_particle, second_particle, constraint_slot,
               load_x, load_y, load_z, load_pinned, rest_length, stiffness,
        input  ready
    );
    modport sink (
        input  valid, func, first_particle, second_particle, constraint_slot,
               load_x, load_y, load_z, load_pinned, rest_length, stiffness,
        output ready
    );
endinterface

/* sv/dcs_out_if.sv */
// ----------------------------------------------------------------------------
// dcs_out_if
// result channel out of the solver
// ----------------------------------------------------------------------------
interface dcs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [23:0]        stress_out;
    logic               vibration;
    logic               broken_out;

    modport source (
        output valid, out_x, out_y, out_z, stress_out, vibration, broken_out,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, stress_out, vibration, broken_out,
        output ready
    );
endinterface

/* sv/dcs_ram.sv */
// ----------------------------------------------------------------------------
// dcs_ram
// generic simple dual port ram, registered read
// ----------------------------------------------------------------------------
module dcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/dcs_mul.sv */
// ----------------------------------------------------------------------------
// dcs_mul
// unsigned shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module dcs_mul #(
    parameter int AW = 35,
    parameter int BW = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_p
);
    localparam int CW = $clog2(BW + 1);

    logic [AW-1:0]    r_a;
    logic [AW+BW-1:0] r_p;
    logic [AW+BW-1:0] n_p;
    logic [AW:0]      sum;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    // add the multiplicand into the high half, then shift one place right
    always_comb begin
        sum = {1'b0, r_p[AW+BW-1:BW]} + (r_p[0] ? {1'b0, r_a} : '0);
        n_p = {sum, r_p[BW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_p    <= {{AW{1'b0}}, i_b};
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_p   <= n_p;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

/* sv/dcs_div.sv */
// ----------------------------------------------------------------------------
// dcs_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dcs_div #(
    parameter int NW = 50,
    parameter int DW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_q
);
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_q;
    logic [DW:0]   shifted;
    logic [DW:0]   trial;
    logic          fits;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    always_comb begin
        shifted = {r_rem, r_q[NW-1]};
        trial   = shifted - {1'b0, r_den};
        fits    = shifted >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= i_num;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? trial[DW-1:0] : shifted[DW-1:0];
                r_q   <= {r_q[NW-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

/* sv/dcs_sqrt.sv */
// ----------------------------------------------------------------------------
// dcs_sqrt
// restoring integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module dcs_sqrt #(
    parameter int RW = 68
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [RW-1:0]   i_rad,
    output logic            o_done,
    output logic [RW/2-1:0] o_root
);
    localparam int HW = RW / 2;
    localparam int CW = $clog2(HW + 1);

    logic [RW-1:0] r_rad;
    logic [HW:0]   r_rem;
    logic [HW-1:0] r_root;
    logic [HW+2:0] shifted;
    logic [HW+2:0] trial;
    logic          fits;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        shifted = {r_rem, r_rad[RW-1:RW-2]};
        trial   = {1'b0, r_root, 2'b01};
        fits    = shifted >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[RW-3:0], 2'b00};
                r_rem  <= fits ? (HW+1)'(shifted - trial) : shifted[HW:0];
                r_root <= {r_root[HW-2:0], fits};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(HW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

/* sv/distance_constraint_solver_core.sv */
// ----------------------------------------------------------------------------
// distance_constraint_solver_core
// position based distance constraint projection over a particle store
// ----------------------------------------------------------------------------
//  channel   dir  handshake          carries
//  i_in      in   valid/ready        func, particles, slot, load data, rest,
//                                    stiffness
//  o_res     out  valid/ready        position or midpoint, stress, flags
//  i_cfg_*   in   write enable only  particle count, vibration and break
//                                    thresholds
//
//  a full solve runs three squarings, a square root, a ratio division, a
//  stiffness product and per axis a normal division plus a product; the
//  products share the one serial multiplier, the divisions the one serial
//  divider, and the square root has its own serial unit
//  after reset a clearing pass zeroes the constraint store; no item is
//  taken until it ends
//  a finished result sits in the output register, the next item is taken
//  meanwhile and waits in the done state if that register is still full
// ----------------------------------------------------------------------------
module distance_constraint_solver_core #(
    parameter int PARTICLES   = 256,
    parameter int CONSTRAINTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    dcs_in_if.sink      i_in,
    dcs_out_if.source   o_res
);
    import dcs_pkg::*;

    localparam int PAW = $clog2(PARTICLES);
    localparam int CAW = (CONSTRAINTS > 1) ? $clog2(CONSTRAINTS) : 1;
    localparam int PW  = 3 * POS_W + 1;   // {pinned, z, y, x}
    localparam int CW  = STRESS_W + 1;    // {broken, stress}

    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_RDA   = 14'b00000000000100,
        S_RDB   = 14'b00000000001000,
        S_SQ    = 14'b00000000010000,
        S_SQRT  = 14'b00000000100000,
        S_RATIO = 14'b00000001000000,
        S_EVAL  = 14'b00000010000000,
        S_ES    = 14'b00000100000000,
        S_NDIV  = 14'b00001000000000,
        S_CMUL  = 14'b00010000000000,
        S_WRA   = 14'b00100000000000,
        S_WRB   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    function automatic logic [PAW-1:0] paddr(input logic [7:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[PAW-1:0];
    endfunction

    function automatic logic [CAW-1:0] caddr(input logic [9:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[CAW-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // configuration
    logic [PCNT_W-1:0]   r_pcount;
    logic [STRESS_W-1:0] r_vthr;
    logic [STRESS_W-1:0] r_bthr;

    // control
    t_state         r_state;
    logic           r_go;       // unit started in this state
    logic [1:0]     r_k;        // axis
    logic [CAW-1:0] r_clr_idx;

    // captured item
    t_func             r_func;
    logic [7:0]        r_a;
    logic [7:0]        r_b;
    logic [9:0]        r_slot;
    logic [REST_W-1:0] r_rest;
    logic [STIFF_W-1:0] r_st;

    // working values
    logic signed [31:0] r_pa [3];
    logic signed [31:0] r_pb [3];
    logic signed [31:0] r_na [3];
    logic signed [31:0] r_nb [3];
    logic               r_pin_a;
    logic               r_pin_b;
    logic [32:0]        r_absd [3];
    logic [2:0]         r_dneg;
    logic [STRESS_W-1:0] r_old_stress;
    logic               r_old_brk;
    logic [67:0]        r_sum;
    logic [33:0]        r_dist;
    logic [49:0]        r_ratio;
    logic               r_err_neg;
    logic [33:0]        r_err_mag;
    logic [33:0]        r_es_mag;
    logic [16:0]        r_nmag;

    // pending result
    logic signed [31:0]  r_rx, r_ry, r_rz;
    logic [STRESS_W-1:0] r_rstress;
    logic                r_rvib, r_rbrk;

    // output register
    logic                r_ov;
    logic signed [31:0]  r_ox, r_oy, r_oz;
    logic [STRESS_W-1:0] r_ostress;
    logic                r_ovib, r_obrk;

    // memories
    logic           p_we;
    logic [PAW-1:0] p_waddr, p_raddr;
    logic [PW-1:0]  p_wdata, p_rdata;
    logic           c_we;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic [CW-1:0]  c_wdata, c_rdata;

    // arithmetic units
    logic        mul_start, mul_done;
    logic [34:0] mul_a;
    logic [32:0] mul_b;
    logic [67:0] mul_p;
    logic        div_start, div_done;
    logic [49:0] div_num, div_q;
    logic [33:0] div_den;
    logic        sqrt_start, sqrt_done;
    logic [33:0] sqrt_root;

    // combinational helpers
    logic               accept;
    logic               a_ok, slot_ok, ends_ok;
    logic [31:0]        cnt_eff;
    logic [REST_W-1:0]  rest_eff;
    logic [STIFF_W-1:0] st_eff;
    logic signed [31:0] pb_ax [3];
    logic signed [32:0] dk [3];
    logic [49:0]        stress_raw;
    logic [STRESS_W-1:0] stress_sat, stress_diff;
    logic               vib, brk;
    logic signed [32:0] mid [3];
    logic [33:0]        cmag, amag;
    logic signed [35:0] amt;
    logic               both_free;

    assign accept = i_in.valid && i_in.ready;

    assign a_ok    = 32'(r_a) < PARTICLES;
    assign slot_ok = 32'(r_slot) < CONSTRAINTS;
    assign cnt_eff = (32'(r_pcount) > PARTICLES) ? PARTICLES : 32'(r_pcount);
    assign ends_ok = (32'(r_a) < cnt_eff) && (32'(r_b) < cnt_eff);

    assign rest_eff = (r_rest == '0) ? REST_W'(1) : r_rest;
    assign st_eff   = (r_st > ONE_Q16) ? ONE_Q16 : r_st;

    // second end arrives from the ram in S_RDB
    assign pb_ax[0] = p_rdata[31:0];
    assign pb_ax[1] = p_rdata[63:32];
    assign pb_ax[2] = p_rdata[95:64];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dk[k]  = {pb_ax[k][31], pb_ax[k]} - {r_pa[k][31], r_pa[k]};
            mid[k] = {r_pa[k][31], r_pa[k]} + {r_pb[k][31], r_pb[k]};
        end
    end

    // stress, vibration and break decision
    always_comb begin
        if (r_ratio >= 50'(ONE_Q16)) begin
            stress_raw = r_ratio - 50'(ONE_Q16);
        end else begin
            stress_raw = 50'(ONE_Q16) - r_ratio;
        end
        stress_sat  = (stress_raw > 50'(24'hffffff)) ? 24'hffffff
                                                     : stress_raw[23:0];
        stress_diff = (stress_sat >= r_old_stress) ? stress_sat - r_old_stress
                                                   : r_old_stress - stress_sat;
        vib = stress_diff > r_vthr;
        brk = (r_bthr != '0) && (r_ratio > 50'(r_bthr));
    end

    // correction of one axis, halved when both ends move
    always_comb begin
        both_free = !r_pin_a && !r_pin_b;
        cmag      = mul_p[49:16];
        amag      = both_free ? {1'b0, cmag[33:1]} : cmag;
        amt       = (r_dneg[r_k] ^ r_err_neg) ? -{2'b00, amag} : {2'b00, amag};
    end

    // unit operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = 35'(r_absd[r_k]);
                mul_b = r_absd[r_k];
            end
            S_ES: begin
                mul_a = 35'(r_err_mag);
                mul_b = 33'(st_eff);
            end
            S_CMUL: begin
                mul_a = 35'(r_es_mag);
                mul_b = 33'(r_nmag);
            end
            default: ;
        endcase
        if (r_state == S_RATIO) begin
            div_num = {r_dist, 16'd0};
            div_den = 34'(rest_eff);
        end else begin
            div_num = 50'({r_absd[r_k], 16'd0});
            div_den = r_dist;
        end
    end

    assign mul_start  = !r_go && (r_state == S_SQ || r_state == S_ES ||
                                  r_state == S_CMUL);
    assign div_start  = !r_go && (r_state == S_RATIO || r_state == S_NDIV);
    assign sqrt_start = !r_go && (r_state == S_SQRT);

    // particle ram ports
    always_comb begin
        p_raddr = (r_state == S_IDLE) ? paddr(i_in.first_particle) : paddr(r_b);
        p_we    = 1'b0;
        p_waddr = paddr(r_a);
        p_wdata = {r_pin_a, r_na[2], r_na[1], r_na[0]};
        case (r_state)
            S_IDLE: begin
                p_we    = accept && (i_in.func == FN_LOAD) &&
                          (32'(i_in.first_particle) < PARTICLES);
                p_waddr = paddr(i_in.first_particle);
                p_wdata = {i_in.load_pinned, i_in.load_z, i_in.load_y, i_in.load_x};
            end
            S_WRA: begin
                p_we = !r_pin_a;
            end
            S_WRB: begin
                p_we    = !r_pin_b;
                p_waddr = paddr(r_b);
                p_wdata = {r_pin_b, r_nb[2], r_nb[1], r_nb[0]};
            end
            default: ;
        endcase
    end

    // constraint ram ports
    always_comb begin
        c_raddr = caddr(i_in.constraint_slot);
        c_we    = 1'b0;
        c_waddr = caddr(r_slot);
        c_wdata = {brk, stress_sat};
        case (r_state)
            S_CLR: begin
                c_we    = 1'b1;
                c_waddr = r_clr_idx;
                c_wdata = '0;
            end
            S_IDLE: begin
                c_we    = accept && (i_in.func == FN_CLEAR) &&
                          (32'(i_in.constraint_slot) < CONSTRAINTS);
                c_waddr = caddr(i_in.constraint_slot);
                c_wdata = '0;
            end
            S_EVAL: begin
                c_we = 1'b1;
            end
            default: ;
        endcase
    end

    dcs_ram #(.WIDTH(PW), .DEPTH(PARTICLES)) u_pram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    dcs_ram #(.WIDTH(CW), .DEPTH(CONSTRAINTS), .AW(CAW)) u_cram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    dcs_mul #(.AW(35), .BW(33)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    dcs_div #(.NW(50), .DW(34)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    dcs_sqrt #(.RW(68)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sum),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= '0;
            r_vthr   <= VTHR_RESET;
            r_bthr   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PCOUNT: r_pcount <= i_cfg_data[PCNT_W-1:0];
                CFG_VTHR:   r_vthr   <= i_cfg_data;
                CFG_BTHR:   r_bthr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_go      <= 1'b0;
            r_k       <= '0;
            r_clr_idx <= '0;
            r_ov      <= 1'b0;
        end else begin
            // the done state refills the output register itself
            if (o_res.valid && o_res.ready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end
            if (mul_start || div_start || sqrt_start) begin
                r_go <= 1'b1;
            end
            case (r_state)
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == CAW'(CONSTRAINTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_func    <= i_in.func;
                        r_a       <= i_in.first_particle;
                        r_b       <= i_in.second_particle;
                        r_slot    <= i_in.constraint_slot;
                        r_rest    <= i_in.rest_length;
                        r_st      <= i_in.stiffness;
                        r_rx      <= '0;
                        r_ry      <= '0;
                        r_rz      <= '0;
                        r_rstress <= '0;
                        r_rvib    <= 1'b0;
                        r_rbrk    <= 1'b0;
                        if (i_in.func == FN_LOAD || i_in.func == FN_CLEAR) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RDA;
                        end
                    end
                end
                S_RDA: begin
                    r_pa[0]      <= p_rdata[31:0];
                    r_pa[1]      <= p_rdata[63:32];
                    r_pa[2]      <= p_rdata[95:64];
                    r_pin_a      <= p_rdata[96];
                    r_old_stress <= c_rdata[STRESS_W-1:0];
                    r_old_brk    <= c_rdata[STRESS_W];
                    if (r_func == FN_READ) begin
                        if (a_ok) begin
                            r_rx <= p_rdata[31:0];
                            r_ry <= p_rdata[63:32];
                            r_rz <= p_rdata[95:64];
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RDB;
                    end
                end
                S_RDB: begin
                    for (int k = 0; k < 3; k++) begin
                        r_pb[k]   <= pb_ax[k];
                        r_dneg[k] <= dk[k][32];
                        r_absd[k] <= dk[k][32] ? 33'(-dk[k]) : 33'(dk[k]);
                    end
                    r_pin_b   <= p_rdata[96];
                    r_sum     <= '0;
                    r_k       <= '0;
                    // skipped solves report the stored slot state
                    r_rstress <= slot_ok ? r_old_stress : '0;
                    r_rbrk    <= slot_ok && r_old_brk;
                    if (!slot_ok || r_old_brk || !ends_ok) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (mul_done) begin
                        r_go  <= 1'b0;
                        r_sum <= r_sum + mul_p;
                        if (r_k == 2'd2) begin
                            r_k     <= '0;
                            r_state <= S_SQRT;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_go   <= 1'b0;
                        r_dist <= sqrt_root;
                        // ends closer than about 0.001 are left alone
                        r_state <= (sqrt_root <= MIN_DIST) ? S_DONE : S_RATIO;
                    end
                end
                S_RATIO: begin
                    if (div_done) begin
                        r_go    <= 1'b0;
                        r_ratio <= div_q;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_rstress <= stress_sat;
                    r_rvib    <= vib;
                    r_rbrk    <= brk;
                    if (vib) begin
                        r_rx <= mid[0][32:1];
                        r_ry <= mid[1][32:1];
                        r_rz <= mid[2][32:1];
                    end
                    r_err_neg <= 34'(rest_eff) > r_dist;
                    r_err_mag <= (34'(rest_eff) > r_dist) ? 34'(rest_eff) - r_dist
                                                          : r_dist - 34'(rest_eff);
                    r_state   <= brk ? S_DONE : S_ES;
                end
                S_ES: begin
                    if (mul_done) begin
                        r_go     <= 1'b0;
                        r_es_mag <= mul_p[49:16];
                        r_k      <= '0;
                        r_state  <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    if (div_done) begin
                        r_go    <= 1'b0;
                        r_nmag  <= div_q[16:0];
                        r_state <= S_CMUL;
                    end
                end
                S_CMUL: begin
                    if (mul_done) begin
                        r_go      <= 1'b0;
                        r_na[r_k] <= sat32(36'(r_pa[r_k]) + amt);
                        r_nb[r_k] <= sat32(36'(r_pb[r_k]) - amt);
                        if (r_k == 2'd2) begin
                            r_state <= S_WRA;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_NDIV;
                        end
                    end
                end
                S_WRA: begin
                    r_state <= S_WRB;
                end
                S_WRB: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov      <= 1'b1;
                        r_ox      <= r_rx;
                        r_oy      <= r_ry;
                        r_oz      <= r_rz;
                        r_ostress <= r_rstress;
                        r_ovib    <= r_rvib;
                        r_obrk    <= r_rbrk;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_res.valid      = r_ov;
    assign o_res.out_x      = r_ox;
    assign o_res.out_y      = r_oy;
    assign o_res.out_z      = r_oz;
    assign o_res.stress_out = r_ostress;
    assign o_res.vibration  = r_ovib;
    assign o_res.broken_out = r_obrk;

    // multiplier finishes only for a step that started it
    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_go && (r_state == S_SQ || r_state == S_ES ||
                               r_state == S_CMUL)))
        else $error("multiplier done outside a multiply step");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_go && (r_state == S_RATIO || r_state == S_NDIV)))
        else $error("divider done outside a divide step");

    a_sqrt_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_go && r_state == S_SQRT))
        else $error("square root done outside its step");

    // a result is never dropped: the done state waits while the output is full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ov && !o_res.ready) |=> (r_state == S_DONE))
        else $error("result overwrote an untaken transfer");
endmodule
